[hw/rtl/fll_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLL package
// Types and constants shared by the frequency-lock loop.
// ----------------------------------------------------------------------------
package fll_pkg;

   typedef enum logic [1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_UPDATE = 2'd1,
      MODE_ADJUST = 2'd2,
      MODE_INIT   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_DISCR_SCALE = 2'd0,
      CSR_GAIN_PROP   = 2'd1,
      CSR_GAIN_ACC    = 2'd2,
      CSR_LOOP_PERIOD = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,      // serial products for cross / dot
      ST_CPRE,      // quadrant pre-rotation
      ST_CORDIC,
      ST_ACCUM,
      ST_ERR,       // sum * scale serial multiply
      ST_ACC,       // gain_acc * err
      ST_PROP,      // gain_prop * err
      ST_FREQ,      // (accel + prop) * period
      ST_WRAP,
      ST_OUT
   } state_type;

   localparam logic [15:0] LAST_I_RESET = 16'sd32767;
   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   function automatic logic [22:0] atan_entry(input logic [4:0] k);
      logic [22:0] r;
      case (k)
         5'd0:  r = 23'd2097152;
         5'd1:  r = 23'd1238021;
         5'd2:  r = 23'd654136;
         5'd3:  r = 23'd332050;
         5'd4:  r = 23'd166669;
         5'd5:  r = 23'd83416;
         5'd6:  r = 23'd41718;
         5'd7:  r = 23'd20860;
         5'd8:  r = 23'd10430;
         5'd9:  r = 23'd5215;
         5'd10: r = 23'd2608;
         5'd11: r = 23'd1304;
         5'd12: r = 23'd652;
         5'd13: r = 23'd326;
         5'd14: r = 23'd163;
         5'd15: r = 23'd81;
         5'd16: r = 23'd41;
         5'd17: r = 23'd20;
         5'd18: r = 23'd10;
         5'd19: r = 23'd5;
         5'd20: r = 23'd3;
         5'd21: r = 23'd1;
         5'd22: r = 23'd1;
         default: r = 23'd0;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/fll_cross_dot_discriminator_loop_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLL with cross/dot discriminator
// Second-order frequency-lock loop, atan2 discriminator by serial CORDIC.
// ----------------------------------------------------------------------------
// One item at a time; the input is ready only in the idle state. After the
// accepting edge a sample item with accumulate set runs the shift-add
// products, one pre-rotation step, the CORDIC iterations and then the
// accumulate, wrap and output states; a loop update runs four bit-serial
// multiplies and then the wrap and output states; a sample without accumulate
// runs accumulate, wrap and output, and an adjust or initialize runs wrap and
// output. The input is ready again once the output state hands off the
// result. Products and multiplies use the shift-add multiplier, and the CORDIC
// uses a single stage. The result register takes the result and frees the
// input side at once; the block waits only while an earlier result is still
// unclaimed.
module fll_cross_dot_discriminator_loop_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[1:0], i_sample[17:2], q_sample[33:18], accumulate[34],
   // half_quadrant[35], freq_value[67:36], accel_value[99:68], zero[103:100]
   input  logic [103:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // carrier_freq[31:0], carrier_accel[63:32]
   output logic [63:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int KW = (CORDIC_STEPS > 23) ? 5 : $clog2(CORDIC_STEPS + 1);

   fll_pkg::state_type state_ff, state_in;

   logic [23:0] discr_scale_ff;
   logic signed [31:0] gain_prop_ff, gain_acc_ff;
   logic [23:0] loop_period_ff;

   logic signed [15:0] last_i_ff, last_i_in, last_q_ff, last_q_in;
   logic signed [23:0] angle_sum_ff, angle_sum_in;
   logic signed [31:0] accel_ff, accel_in, freq_ff, freq_in;

   logic [1:0]  mode_ff, mode_in;
   logic signed [15:0] iv_ff, iv_in, qv_ff, qv_in;
   logic acc_ff, acc_in, halfq_ff, halfq_in;
   logic signed [31:0] fval_ff, fval_in, aval_ff, aval_in;

   // shift-add multiplier: product += mcand << bit when multiplier bit set
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] mcand_ff, mcand_in;
   logic [31:0] mplr_ff, mplr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic signed [63:0] prop_ff, prop_in;

   // cross/dot: four 16x16 products in parallel, 16 bit steps
   logic signed [33:0] cross_ff, cross_in, dot_ff, dot_in;

   logic signed [35:0] x_ff, x_in, y_ff, y_in;
   logic signed [25:0] z_ff, z_in;
   logic [KW-1:0] k_ff, k_in;

   logic signed [63:0] rsum;
   logic signed [31:0] out_f_ff, out_f_in, out_a_ff, out_a_in;
   logic rsp_valid_ff, rsp_valid_in;

   function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
      if (v > fll_pkg::S32_MAX) return fll_pkg::S32_MAX;
      if (v < fll_pkg::S32_MIN) return fll_pkg::S32_MIN;
      return v;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         discr_scale_ff <= '0;
         gain_prop_ff   <= '0;
         gain_acc_ff    <= '0;
         loop_period_ff <= '0;
      end else if (csr_we) begin
         unique case (fll_pkg::csr_index_type'(csr_index))
            fll_pkg::CSR_DISCR_SCALE: discr_scale_ff <= csr_wdata[23:0];
            fll_pkg::CSR_GAIN_PROP:   gain_prop_ff   <= csr_wdata;
            fll_pkg::CSR_GAIN_ACC:    gain_acc_ff    <= csr_wdata;
            fll_pkg::CSR_LOOP_PERIOD: loop_period_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fll_pkg::ST_IDLE;
         last_i_ff    <= fll_pkg::LAST_I_RESET;
         last_q_ff    <= '0;
         angle_sum_ff <= '0;
         accel_ff     <= '0;
         freq_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_i_ff    <= last_i_in;
         last_q_ff    <= last_q_in;
         angle_sum_ff <= angle_sum_in;
         accel_ff     <= accel_in;
         freq_ff      <= freq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      iv_ff    <= iv_in;
      qv_ff    <= qv_in;
      acc_ff   <= acc_in;
      halfq_ff <= halfq_in;
      fval_ff  <= fval_in;
      aval_ff  <= aval_in;
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
      cnt_ff   <= cnt_in;
      prop_ff  <= prop_in;
      cross_ff <= cross_in;
      dot_ff   <= dot_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      k_ff     <= k_in;
      out_f_ff <= out_f_in;
      out_a_ff <= out_a_in;
   end

   assign req_tready = (state_ff == fll_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_a_ff, out_f_ff};

   always_comb begin
      logic signed [63:0] t;
      logic signed [35:0] xs, ys;
      logic signed [25:0] zr;
      logic signed [15:0] a;
      logic signed [24:0] s;
      logic signed [33:0] pc, pd;
      state_in     = state_ff;
      last_i_in    = last_i_ff;
      last_q_in    = last_q_ff;
      angle_sum_in = angle_sum_ff;
      accel_in     = accel_ff;
      freq_in      = freq_ff;
      mode_in      = mode_ff;
      iv_in        = iv_ff;
      qv_in        = qv_ff;
      acc_in       = acc_ff;
      halfq_in     = halfq_ff;
      fval_in      = fval_ff;
      aval_in      = aval_ff;
      prod_in      = prod_ff;
      mcand_in     = mcand_ff;
      mplr_in      = mplr_ff;
      cnt_in       = cnt_ff;
      prop_in      = prop_ff;
      cross_in     = cross_ff;
      dot_in       = dot_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      k_in         = k_ff;
      out_f_in     = out_f_ff;
      out_a_in     = out_a_ff;
      rsp_valid_in = rsp_valid_ff;
      rsum         = '0;
      t = '0; xs = '0; ys = '0; zr = '0; a = '0; s = '0; pc = '0; pd = '0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         fll_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tdata[1:0];
               iv_in    = req_tdata[17:2];
               qv_in    = req_tdata[33:18];
               acc_in   = req_tdata[34];
               halfq_in = req_tdata[35];
               fval_in  = req_tdata[67:36];
               aval_in  = req_tdata[99:68];
               cross_in = '0;
               dot_in   = '0;
               cnt_in   = '0;
               unique case (fll_pkg::mode_type'(req_tdata[1:0]))
                  fll_pkg::MODE_SAMPLE:
                     state_in = req_tdata[34] ? fll_pkg::ST_PROD : fll_pkg::ST_ACCUM;
                  fll_pkg::MODE_UPDATE: begin
                     prod_in  = '0;
                     mcand_in = 64'(angle_sum_ff);
                     mplr_in  = {8'd0, discr_scale_ff};
                     state_in = fll_pkg::ST_ERR;
                  end
                  default: state_in = fll_pkg::ST_WRAP;
               endcase
            end
         end
         fll_pkg::ST_PROD: begin
            // bit cnt of multipliers i (and q); last bit is sign (negative weight)
            pc = 34'(last_i_ff) <<< cnt_ff[3:0];
            pd = 34'(last_q_ff) <<< cnt_ff[3:0];
            if (cnt_ff[3:0] == 4'd15) begin
               pc = -pc;
               pd = -pd;
            end
            // cross = last_i*q - last_q*i ; dot = last_i*i + last_q*q
            if (qv_ff[cnt_ff[3:0]]) begin
               cross_in = cross_in + pc;
               dot_in   = dot_in + pd;
            end
            if (iv_ff[cnt_ff[3:0]]) begin
               cross_in = cross_in - pd;
               dot_in   = dot_in + pc;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[3:0] == 4'd15) state_in = fll_pkg::ST_CPRE;
         end
         fll_pkg::ST_CPRE: begin
            k_in = '0;
            if (dot_ff < 0) begin
               if (cross_ff >= 0) begin
                  x_in = 36'(cross_ff); y_in = -36'(dot_ff); z_in = 26'sd4194304;
               end else begin
                  x_in = -36'(cross_ff); y_in = 36'(dot_ff); z_in = -26'sd4194304;
               end
            end else begin
               x_in = 36'(dot_ff); y_in = 36'(cross_ff); z_in = '0;
            end
            state_in = fll_pkg::ST_CORDIC;
         end
         fll_pkg::ST_CORDIC: begin
            if (k_ff == KW'(CORDIC_STEPS)) begin
               state_in = fll_pkg::ST_ACCUM;
            end else begin
               xs = x_ff >>> k_ff;
               ys = y_ff >>> k_ff;
               if (y_ff >= 0) begin
                  x_in = x_ff + ys; y_in = y_ff - xs;
                  z_in = z_ff + 26'(fll_pkg::atan_entry(5'(k_ff)));
               end else begin
                  x_in = x_ff - ys; y_in = y_ff + xs;
                  z_in = z_ff - 26'(fll_pkg::atan_entry(5'(k_ff)));
               end
               k_in = k_ff + KW'(1);
            end
         end
         fll_pkg::ST_ACCUM: begin
            if (acc_ff) begin
               if (cross_ff == 0 && dot_ff == 0) begin
                  a = '0;
               end else begin
                  zr = (z_ff + 26'sd128) >>> 8;
                  if (zr > 26'sd32768) zr = 26'sd32768;
                  if (zr < -26'sd32768) zr = -26'sd32768;
                  // 32768 fits only after fold or as a 17 bit value
                  if (halfq_ff && (zr > 26'sd16384 || zr < -26'sd16384))
                     zr = (zr > 0) ? zr - 26'sd32768 : zr + 26'sd32768;
                  s = 25'(angle_sum_ff) + 25'(zr);
                  a = 16'sd0;
               end
               if (!(cross_ff == 0 && dot_ff == 0)) begin
                  if (s > 25'sd8388607) s = 25'sd8388607;
                  if (s < -25'sd8388608) s = -25'sd8388608;
                  angle_sum_in = 24'(s);
               end else begin
                  angle_sum_in = angle_sum_ff + 24'(a);
               end
            end
            last_i_in = iv_ff;
            last_q_in = qv_ff;
            state_in  = fll_pkg::ST_WRAP;
         end
         fll_pkg::ST_ERR, fll_pkg::ST_ACC, fll_pkg::ST_PROP, fll_pkg::ST_FREQ: begin
            if (mplr_ff[cnt_ff[4:0]])
               prod_in = prod_ff + (mcand_ff <<< cnt_ff[4:0]);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               cnt_in = '0;
               t = prod_in;
               prod_in = '0;
               unique case (state_ff)
                  fll_pkg::ST_ERR: begin
                     angle_sum_in = '0;
                     t = sat32((t + 64'sd32768) >>> 16);
                     prop_in  = t;
                     mcand_in = 64'(gain_acc_ff);
                     mplr_in  = t[31:0];
                     state_in = fll_pkg::ST_ACC;
                  end
                  fll_pkg::ST_ACC: begin
                     // signed multiplier: subtract mcand << 32 when sign set
                     if (mplr_ff[31]) t = t - (mcand_ff <<< 32);
                     t = sat32(64'(accel_ff) + ((t + 64'sd32768) >>> 16));
                     accel_in = t[31:0];
                     mcand_in = 64'(gain_prop_ff);
                     state_in = fll_pkg::ST_PROP;
                  end
                  fll_pkg::ST_PROP: begin
                     if (mplr_ff[31]) t = t - (mcand_ff <<< 32);
                     t = 64'(accel_ff) + ((t + 64'sd32768) >>> 16);
                     mcand_in = t;
                     mplr_in  = {8'd0, loop_period_ff};
                     state_in = fll_pkg::ST_FREQ;
                  end
                  default: begin
                     t = sat32(64'(freq_ff) + ((t + 64'sd8388608) >>> 24));
                     freq_in  = t[31:0];
                     state_in = fll_pkg::ST_WRAP;
                  end
               endcase
            end
         end
         fll_pkg::ST_WRAP: begin
            unique case (fll_pkg::mode_type'(mode_ff))
               fll_pkg::MODE_ADJUST: begin
                  rsum = sat32(64'(freq_ff) + 64'(fval_ff));
                  freq_in = rsum[31:0];
               end
               fll_pkg::MODE_INIT: begin
                  freq_in      = fval_ff;
                  accel_in     = aval_ff;
                  angle_sum_in = '0;
                  last_i_in    = fll_pkg::LAST_I_RESET;
                  last_q_in    = '0;
               end
               default: ;
            endcase
            state_in = fll_pkg::ST_OUT;
         end
         fll_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_f_in     = freq_ff;
               out_a_in     = accel_ff;
               rsp_valid_in = 1'b1;
               state_in     = fll_pkg::ST_IDLE;
            end
         end
         default: state_in = fll_pkg::ST_IDLE;
      endcase
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != fll_pkg::ST_IDLE) |-> !req_tready)
      else $error("input accepted while busy");
   a_out_from_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fll_pkg::ST_OUT && state_in == fll_pkg::ST_IDLE) |=> rsp_tvalid)
      else $error("result lost");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLL cross/dot discriminator loop testbench
// Drives sample, update, adjust and init items through the stream ports
// under random bursts and receiver stalls, predicts carrier frequency and
// acceleration with an in-bench loop model, and checks every result.
// ----------------------------------------------------------------------------
module tb;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;

   typedef struct packed {
      logic signed [31:0] freq;
      logic signed [31:0] accel;
   } loop_out_type;

   loop_out_type freq_accel_q[$];
   int        errors;
   int        hold_off;
   int        burst_left;

   // loop model state and registers
   longint m_scale, m_kp, m_ka, m_period;
   longint m_last_i, m_last_q, m_sum, m_accel, m_freq;

   fll_cross_dot_discriminator_loop_top dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAILURE");
      $finish;
   end

   function automatic longint rshr(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint phase_angle(longint y, longint x);
      longint atan_lut[24] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
         41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
         41, 20, 10, 5, 3, 1, 1, 0};
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 4194304;
         end else begin
            t = x; x = -y; y = t; z = -4194304;
         end
      end
      for (int k = 0; k < 16; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (y >= 0) begin
            x += ys; y -= xs; z += atan_lut[k];
         end else begin
            x -= ys; y += xs; z -= atan_lut[k];
         end
      end
      return sat(rshr(z, 8), -32768, 32768);
   endfunction

   task automatic loop_predict(fll_pkg::mode_type mode, logic signed [15:0] iv,
                               logic signed [15:0] qv, logic acc, logic hq,
                               logic signed [31:0] fv, logic signed [31:0] av);
      longint a, err, s;
      loop_out_type r;
      case (mode)
         fll_pkg::MODE_SAMPLE: begin
            if (acc) begin
               a = phase_angle(m_last_i * longint'(qv) - longint'(iv) * m_last_q,
                               longint'(iv) * m_last_i + longint'(qv) * m_last_q);
               if (hq && (a > 16384 || a < -16384)) a = a > 0 ? a - 32768 : a + 32768;
               m_sum = sat(m_sum + a, -8388608, 8388607);
            end
            m_last_i = iv;
            m_last_q = qv;
         end
         fll_pkg::MODE_UPDATE: begin
            err = sat(rshr(m_sum * m_scale, 16), fll_pkg::S32_MIN, fll_pkg::S32_MAX);
            m_sum = 0;
            m_accel = sat(m_accel + rshr(m_ka * err, 16), fll_pkg::S32_MIN,
                          fll_pkg::S32_MAX);
            s = m_accel + rshr(m_kp * err, 16);
            m_freq = sat(m_freq + rshr(s * m_period, 24), fll_pkg::S32_MIN,
                         fll_pkg::S32_MAX);
         end
         fll_pkg::MODE_ADJUST:
            m_freq = sat(m_freq + fv, fll_pkg::S32_MIN, fll_pkg::S32_MAX);
         default: begin
            m_freq = fv;
            m_accel = av;
            m_sum = 0;
            m_last_i = 32767;
            m_last_q = 0;
         end
      endcase
      r.freq = m_freq[31:0];
      r.accel = m_accel[31:0];
      freq_accel_q.push_back(r);
   endtask

   // result checker
   always @(posedge clock) begin
      loop_out_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (freq_accel_q.size() == 0) begin
            $display("%t unexpected item: actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = freq_accel_q.pop_front();
            if (rsp_tdata[31:0] !== e.freq) begin
               $display("%t carrier_freq: expected %0d actual %0d", $time, e.freq,
                        $signed(rsp_tdata[31:0]));
               errors++;
            end
            if (rsp_tdata[63:32] !== e.accel) begin
               $display("%t carrier_accel: expected %0d actual %0d", $time, e.accel,
                        $signed(rsp_tdata[63:32]));
               errors++;
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      int phase, style;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 1'b0;
      end else begin
         phase = (phase + 1) % 64;
         if (phase == 0) style = $urandom_range(0, 2);
         case (style)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   task automatic send_item(fll_pkg::mode_type mode, logic [15:0] iv, logic [15:0] qv,
                            logic acc, logic hq, logic [31:0] fv, logic [31:0] av);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, av, fv, hq, acc, qv, iv, mode};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      loop_predict(mode, iv, qv, acc, hq, fv, av);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (freq_accel_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(fll_pkg::csr_index_type idx, logic [31:0] val);
      drain();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         fll_pkg::CSR_DISCR_SCALE: m_scale = val[23:0];
         fll_pkg::CSR_GAIN_PROP:   m_kp = longint'($signed(val));
         fll_pkg::CSR_GAIN_ACC:    m_ka = longint'($signed(val));
         default:                  m_period = val[23:0];
      endcase
   endtask

   task automatic set_loop(logic [31:0] s, logic [31:0] kp, logic [31:0] ka,
                           logic [31:0] p);
      write_csr(fll_pkg::CSR_DISCR_SCALE, s);
      write_csr(fll_pkg::CSR_GAIN_PROP, kp);
      write_csr(fll_pkg::CSR_GAIN_ACC, ka);
      write_csr(fll_pkg::CSR_LOOP_PERIOD, p);
   endtask

   task automatic sample(logic [15:0] iv, logic [15:0] qv, logic acc, logic hq);
      send_item(fll_pkg::MODE_SAMPLE, iv, qv, acc, hq, $urandom, $urandom);
   endtask

   task automatic send_random(fll_pkg::mode_type mode);
      send_item(mode, 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                $urandom, $urandom);
   endtask

   task automatic test_directed();
      set_loop(32'h00FFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h00FFFFFF);
      sample(16'h0000, 16'h0000, 1'b1, 1'b0);
      sample(16'h8000, 16'h0000, 1'b1, 1'b0);
      sample(16'h7FFF, 16'h0000, 1'b1, 1'b1);
      sample(16'h8000, 16'h8000, 1'b1, 1'b0);
      sample(16'h7FFF, 16'h8000, 1'b1, 1'b1);
      sample(16'h8000, 16'h7FFF, 1'b1, 1'b1);
      sample(16'h0000, 16'h7FFF, 1'b0, 1'b1);
      sample(16'hFFFF, 16'h0001, 1'b1, 1'b0);
      send_item(fll_pkg::MODE_UPDATE, '0, '0, '0, '0, '0, '0);
      send_item(fll_pkg::MODE_INIT, '0, '0, '0, '0, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_item(fll_pkg::MODE_ADJUST, '0, '0, '0, '0, 32'h7FFFFFFF, '0);
      send_item(fll_pkg::MODE_INIT, '0, '0, '0, '0, 32'h80000000, 32'h80000000);
      send_item(fll_pkg::MODE_ADJUST, '0, '0, '0, '0, 32'h80000000, '0);
      send_item(fll_pkg::MODE_UPDATE, '0, '0, '0, '0, '0, '0);
      for (int k = 0; k < 6; k++)
         sample(16'h8000, k[0] ? 16'h0000 : 16'h0001, 1'b1, 1'b0);
      send_item(fll_pkg::MODE_UPDATE, '0, '0, '0, '0, '0, '0);
      set_loop('0, '0, '0, '0);
      sample(16'h1234, 16'h4321, 1'b1, 1'b0);
      send_item(fll_pkg::MODE_UPDATE, '0, '0, '0, '0, '0, '0);
   endtask

   task automatic test_random(int n);
      int count, len;
      count = 0;
      while (count < n) begin
         set_loop($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096),
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 65536) - 32768,
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8192) - 4096,
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 65536));
         for (int b = 0; b < 8 && count < n; b++) begin
            if ($urandom_range(0, 3) == 0) begin
               send_random(fll_pkg::MODE_INIT);
               count++;
            end
            len = $urandom_range(1, 20);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 15) == 0) sample('0, '0, 1'b1, 1'($urandom));
               else sample(16'($urandom), 16'($urandom), $urandom_range(0, 7) != 0,
                           1'($urandom));
            end
            count += len;
            if ($urandom_range(0, 4) == 0) begin
               send_random(fll_pkg::MODE_ADJUST);
               count++;
            end
            send_random(fll_pkg::MODE_UPDATE);
            count++;
            if ($urandom_range(0, 9) == 0) drain();
         end
      end
   endtask

   task automatic test_backpressure();
      drain();
      hold_off = 400;
      for (int k = 0; k < 10; k++)
         sample(16'($urandom), 16'($urandom), 1'b1, 1'($urandom));
      send_item(fll_pkg::MODE_UPDATE, '0, '0, '0, '0, '0, '0);
   endtask

   initial begin
      errors = 0;
      hold_off = 0;
      burst_left = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = fll_pkg::CSR_DISCR_SCALE;
      csr_wdata = '0;
      m_scale = 0; m_kp = 0; m_ka = 0; m_period = 0;
      m_last_i = 32767; m_last_q = 0; m_sum = 0; m_accel = 0; m_freq = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(1100);
      test_backpressure();
      req_tvalid <= 1'b0;
      drain();
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
